// File: rtl/txgtc_pkg.sv
`default_nettype none

package txgtc_pkg;

    localparam int P_TABLE_POINTS = 11;
    localparam int P_MAX_POINTS   = 12;
    localparam int P_BIDX_W       = 4;
    localparam int P_CODE_W       = 15;
    localparam int P_GAIN_W       = 16;
    localparam int P_CFG_DATA_W   = 64;
    localparam int P_CFG_IDX_W    = 3;
    localparam int P_DIV_STEPS    = 24;

    localparam logic [P_CFG_IDX_W-1:0] REG_GAIN_LOW    = 3'd0;
    localparam logic [P_CFG_IDX_W-1:0] REG_GAIN_MID    = 3'd1;
    localparam logic [P_CFG_IDX_W-1:0] REG_GAIN_HIGH   = 3'd2;
    localparam logic [P_CFG_IDX_W-1:0] REG_CALIB_CODE  = 3'd3;
    localparam logic [P_CFG_IDX_W-1:0] REG_COMP_ENABLE = 3'd4;
    localparam logic [P_CFG_IDX_W-1:0] REG_WINDOW_LOW  = 3'd5;
    localparam logic [P_CFG_IDX_W-1:0] REG_WINDOW_HIGH = 3'd6;

    localparam logic [P_CODE_W-1:0] P_CALIB_RESET   = 15'd15575;
    localparam logic [P_CODE_W-1:0] P_WIN_LOW_RESET = 15'd10000;
    localparam logic [P_CODE_W-1:0] P_WIN_HI_RESET  = 15'd20000;

    function automatic logic [P_CODE_W-1:0] base_code(input logic [P_BIDX_W-1:0] idx);
        logic [P_CODE_W-1:0] v;
        case (idx)
            4'd0:    v = 15'd14420;
            4'd1:    v = 15'd14675;
            4'd2:    v = 15'd14910;
            4'd3:    v = 15'd15124;
            4'd4:    v = 15'd15350;
            4'd5:    v = 15'd15575;
            4'd6:    v = 15'd15790;
            4'd7:    v = 15'd16022;
            4'd8:    v = 15'd16234;
            4'd9:    v = 15'd16466;
            4'd10:   v = 15'd16694;
            4'd11:   v = 15'd16922;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tx_gain_thermal_compensation_core.sv
// Flow: a rejected code sets the result straight from idle, a code clamped to an end gain goes
// through the clamp state, and an interpolated code goes through a binary search with a final
// check, one multiply and a bit-serial divider over a 24-bit dividend; search and divide share one subtractor.
// Throughput: one word at a time; the input stalls until the result is loaded into the output
// register. Reset is synchronous, active low, and loads the register defaults.
`default_nettype none

module tx_gain_thermal_compensation_core #(
    parameter int TABLE_POINTS = txgtc_pkg::P_TABLE_POINTS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [txgtc_pkg::P_CODE_W-1:0]        i_temp_code,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [txgtc_pkg::P_GAIN_W-1:0]      o_gain_offset,
    output logic                                       o_accepted,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [txgtc_pkg::P_CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [txgtc_pkg::P_CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IDX_W = (TABLE_POINTS > 2) ? $clog2(TABLE_POINTS) : 1;
    localparam int LAST  = TABLE_POINTS - 1;
    localparam int MID   = (TABLE_POINTS - 1) / 2;
    localparam int GW    = txgtc_pkg::P_GAIN_W;
    localparam int BW    = txgtc_pkg::P_BIDX_W;
    localparam int DW    = txgtc_pkg::P_DIV_STEPS;
    localparam int CW    = $clog2(txgtc_pkg::P_DIV_STEPS);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CLAMP  = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_DIFF   = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    typedef enum logic [0:0] {
        O_BUSY = 1'b0,
        O_DONE = 1'b1
    } t_out_phase;

    function automatic logic signed [16:0] rel_code(input logic [BW-1:0] idx);
        return signed'({2'b00, txgtc_pkg::base_code(idx)})
             - signed'({2'b00, txgtc_pkg::base_code(BW'(MID))});
    endfunction

    // configuration
    logic [63:0] r_gain_low;
    logic [63:0] r_gain_mid;
    logic [47:0] r_gain_high;
    logic [14:0] r_calib;
    logic        r_enable;
    logic [14:0] r_win_low;
    logic [14:0] r_win_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_low  <= '0;
            r_gain_mid  <= '0;
            r_gain_high <= '0;
            r_calib     <= txgtc_pkg::P_CALIB_RESET;
            r_enable    <= 1'b0;
            r_win_low   <= txgtc_pkg::P_WIN_LOW_RESET;
            r_win_high  <= txgtc_pkg::P_WIN_HI_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                txgtc_pkg::REG_GAIN_LOW:    r_gain_low  <= i_cfg_data;
                txgtc_pkg::REG_GAIN_MID:    r_gain_mid  <= i_cfg_data;
                txgtc_pkg::REG_GAIN_HIGH:   r_gain_high <= i_cfg_data[47:0];
                txgtc_pkg::REG_CALIB_CODE:  r_calib     <= i_cfg_data[14:0];
                txgtc_pkg::REG_COMP_ENABLE: r_enable    <= i_cfg_data[0];
                txgtc_pkg::REG_WINDOW_LOW:  r_win_low   <= i_cfg_data[14:0];
                txgtc_pkg::REG_WINDOW_HIGH: r_win_high  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic signed [GW-1:0] w_gain [TABLE_POINTS];

    for (genvar gi = 0; gi < TABLE_POINTS; gi++) begin : g_gain
        if (gi < 4) begin : g_low
            assign w_gain[gi] = r_gain_low[GW*gi +: GW];
        end else if (gi < 8) begin : g_mid
            assign w_gain[gi] = r_gain_mid[GW*(gi-4) +: GW];
        end else if (gi < 11) begin : g_high
            assign w_gain[gi] = r_gain_high[GW*(gi-8) +: GW];
        end else begin : g_zero
            assign w_gain[gi] = '0;
        end
    end

    // datapath
    t_state              r_state;
    logic signed [16:0]  r_d;
    logic [IDX_W-1:0]    r_lo;
    logic [IDX_W-1:0]    r_hi;
    logic [7:0]          r_x;
    logic [7:0]          r_den;
    logic [7:0]          r_rem;
    logic [15:0]         r_gmag;
    logic                r_neg;
    logic signed [GW-1:0] r_g0;
    logic [DW-1:0]       r_num;
    logic [CW-1:0]       r_cnt;
    logic signed [GW-1:0] r_res_gain;
    logic                r_res_ok;
    t_out_phase          r_phase;
    logic                r_out_valid;
    logic signed [GW-1:0] r_out_gain;
    logic                r_out_ok;

    logic signed [17:0]  w_sub_a;
    logic signed [17:0]  w_sub_b;
    logic signed [17:0]  w_sub_d;
    logic [IDX_W-1:0]    w_mid;
    logic [IDX_W:0]      w_lo_inc;
    logic                w_in_ok;
    logic [8:0]          w_trial;
    logic signed [16:0]  w_gdiff;
    logic signed [16:0]  w_gabs;
    logic signed [17:0]  w_q;
    logic signed [17:0]  w_sum;
    logic                w_load_out;

    assign w_mid    = IDX_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign w_lo_inc = {1'b0, r_lo} + (IDX_W+1)'(1);
    assign w_in_ok  = r_enable && (i_temp_code >= r_win_low) && (i_temp_code <= r_win_high);
    assign w_trial  = {r_rem, r_num[DW-1]};
    assign w_gdiff  = {w_gain[w_lo_inc[IDX_W-1:0]][GW-1], w_gain[w_lo_inc[IDX_W-1:0]]}
                    - {w_gain[r_lo][GW-1], w_gain[r_lo]};
    assign w_gabs   = w_gdiff[16] ? -w_gdiff : w_gdiff;
    assign w_q      = {1'b0, r_num[16:0]};
    assign w_sum    = {{2{r_g0[GW-1]}}, r_g0} + (r_neg ? -w_q : w_q);

    // shared subtractor
    always_comb begin
        case (r_state)
            S_IDLE: begin
                w_sub_a = {3'b000, i_temp_code};
                w_sub_b = {3'b000, r_calib};
            end
            S_SEARCH: begin
                w_sub_a = {r_d[16], r_d};
                w_sub_b = 18'(rel_code(BW'(w_mid)));
            end
            S_DIFF: begin
                w_sub_a = {r_d[16], r_d};
                w_sub_b = 18'(rel_code(BW'(r_lo)));
            end
            S_DIV: begin
                w_sub_a = {9'd0, w_trial};
                w_sub_b = {10'd0, r_den};
            end
            default: begin
                w_sub_a = '0;
                w_sub_b = '0;
            end
        endcase
    end

    assign w_sub_d = w_sub_a - w_sub_b;

    assign w_load_out = (r_phase == O_DONE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= O_BUSY;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_phase == O_BUSY && i_in_valid) begin
                        r_d <= w_sub_d[16:0];
                        if (w_in_ok) begin
                            r_state <= S_CLAMP;
                        end else begin
                            r_res_gain <= '0;
                            r_res_ok   <= 1'b0;
                            r_phase    <= O_DONE;
                        end
                    end else if (w_load_out) begin
                        r_phase <= O_BUSY;
                    end
                end
                S_CLAMP: begin
                    r_res_ok <= 1'b1;
                    r_lo     <= '0;
                    r_hi     <= IDX_W'(LAST);
                    if (r_d <= rel_code(BW'(0))) begin
                        r_res_gain <= w_gain[0];
                        r_phase    <= O_DONE;
                        r_state    <= S_IDLE;
                    end else if (r_d >= rel_code(BW'(LAST))) begin
                        r_res_gain <= w_gain[LAST];
                        r_phase    <= O_DONE;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (w_lo_inc == {1'b0, r_hi}) begin
                        r_state <= S_DIFF;
                    end else if (w_sub_d[17]) begin
                        r_hi <= w_mid;
                    end else begin
                        r_lo <= w_mid;
                    end
                end
                S_DIFF: begin
                    r_x    <= w_sub_d[7:0];
                    r_den  <= 8'(rel_code(BW'(w_lo_inc[IDX_W-1:0])) - rel_code(BW'(r_lo)));
                    r_neg  <= w_gdiff[16];
                    r_gmag <= w_gabs[15:0];
                    r_g0   <= w_gain[r_lo];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_num   <= r_x * r_gmag;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_sub_d[17]) begin
                        r_rem <= w_trial[7:0];
                        r_num <= {r_num[DW-2:0], 1'b0};
                    end else begin
                        r_rem <= w_sub_d[7:0];
                        r_num <= {r_num[DW-2:0], 1'b1};
                    end
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(DW - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_res_gain <= w_sum[GW-1:0];
                    r_phase    <= O_DONE;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_gain <= r_res_gain;
            r_out_ok   <= r_res_ok;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE) || (r_phase == O_DONE);
    assign o_out_valid   = r_out_valid;
    assign o_gain_offset = r_out_gain;
    assign o_accepted    = r_out_ok;

`ifndef ASSERT_OFF
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> r_out_gain == '0)
        else $error("rejected word carries nonzero gain");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEARCH |-> r_lo < r_hi)
        else $error("search bounds crossed");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_den)
        else $error("divider remainder out of range");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_in_stall)
        else $error("input open while a word is in work");
`endif

endmodule

`default_nettype wire

// File: test/tx_gain_thermal_compensation_core_tb.sv
`timescale 1ns / 100ps

module tx_gain_thermal_compensation_core_tb;

    localparam int  CLK_HALF      = 6;
    localparam int  RESET_CYCLES  = 11;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  NUM_PHASES    = 8;
    localparam int  PHASE_WORDS   = 210;
    localparam int  NUM_DIR_ROWS  = 38;
    localparam int  MID_IDX       = (txgtc_pkg::P_TABLE_POINTS - 1) / 2;
    localparam int  LAST_IDX      = txgtc_pkg::P_TABLE_POINTS - 1;
    localparam int  CODE_MAX      = (1 << txgtc_pkg::P_CODE_W) - 1;
    localparam real TIMEOUT_NS    = 12_000_000.0;

    localparam logic [63:0] DIR_GAIN_LOW  = 64'h0100_0000_FF30_8000;
    localparam logic [63:0] DIR_GAIN_MID  = 64'h7FFF_8000_1234_FF30;
    localparam logic [63:0] DIR_GAIN_HIGH = 64'h0000_0050_FFFF_7FFF;

    typedef struct packed {
        logic signed [txgtc_pkg::P_GAIN_W-1:0] gain;
        logic                                  acc;
    } t_gain_res;

    typedef enum logic [1:0] {ROW_WRITE, ROW_CODE, ROW_CODE_EXP} t_row_kind;

    typedef struct packed {
        t_row_kind                             kind;
        logic [txgtc_pkg::P_CFG_IDX_W-1:0]     idx;
        logic [txgtc_pkg::P_CFG_DATA_W-1:0]    value;
        logic signed [txgtc_pkg::P_GAIN_W-1:0] gain;
        logic                                  acc;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [NUM_DIR_ROWS] = '{
        '{ROW_CODE_EXP, '0, 64'd0,      16'sd0,      1'b0},
        '{ROW_CODE_EXP, '0, 64'd15575,  16'sd0,      1'b0},
        '{ROW_CODE_EXP, '0, 64'd32767,  16'sd0,      1'b0},
        '{ROW_WRITE, txgtc_pkg::REG_GAIN_LOW,    DIR_GAIN_LOW,  16'sd0, 1'b0},
        '{ROW_WRITE, txgtc_pkg::REG_GAIN_MID,    DIR_GAIN_MID,  16'sd0, 1'b0},
        '{ROW_WRITE, txgtc_pkg::REG_GAIN_HIGH,   DIR_GAIN_HIGH, 16'sd0, 1'b0},
        '{ROW_WRITE, txgtc_pkg::REG_COMP_ENABLE, 64'd1,         16'sd0, 1'b0},
        '{ROW_WRITE, txgtc_pkg::REG_WINDOW_LOW,  64'd0,         16'sd0, 1'b0},
        '{ROW_WRITE, txgtc_pkg::REG_WINDOW_HIGH, 64'd32767,     16'sd0, 1'b0},
        '{ROW_CODE_EXP, '0, 64'd0,      16'sh8000,   1'b1},
        '{ROW_CODE_EXP, '0, 64'd14420,  16'sh8000,   1'b1},
        '{ROW_CODE_EXP, '0, 64'd32767,  16'sd80,     1'b1},
        '{ROW_CODE_EXP, '0, 64'd16694,  16'sd80,     1'b1},
        '{ROW_CODE,     '0, 64'd14421,  16'sd0,      1'b0},
        '{ROW_CODE,     '0, 64'd14675,  16'sd0,      1'b0},
        '{ROW_CODE,     '0, 64'd15000,  16'sd0,      1'b0},
        '{ROW_CODE,     '0, 64'd15575,  16'sd0,      1'b0},
        '{ROW_CODE,     '0, 64'd16000,  16'sd0,      1'b0},
        '{ROW_CODE,     '0, 64'd16300,  16'sd0,      1'b0},
        '{ROW_CODE,     '0, 64'd16500,  16'sd0,      1'b0},
        '{ROW_CODE,     '0, 64'd16693,  16'sd0,      1'b0},
        '{ROW_WRITE, txgtc_pkg::REG_CALIB_CODE,  64'd0,         16'sd0, 1'b0},
        '{ROW_CODE,     '0, 64'd0,      16'sd0,      1'b0},
        '{ROW_CODE_EXP, '0, 64'd32767,  16'sd80,     1'b1},
        '{ROW_WRITE, txgtc_pkg::REG_CALIB_CODE,  64'd32767,     16'sd0, 1'b0},
        '{ROW_CODE,     '0, 64'd32000,  16'sd0,      1'b0},
        '{ROW_CODE,     '0, 64'd32767,  16'sd0,      1'b0},
        '{ROW_CODE_EXP, '0, 64'd100,    16'sh8000,   1'b1},
        '{ROW_WRITE, txgtc_pkg::REG_CALIB_CODE,  64'd15575,     16'sd0, 1'b0},
        '{ROW_WRITE, txgtc_pkg::REG_WINDOW_LOW,  64'd14000,     16'sd0, 1'b0},
        '{ROW_WRITE, txgtc_pkg::REG_WINDOW_HIGH, 64'd17000,     16'sd0, 1'b0},
        '{ROW_CODE_EXP, '0, 64'd13999,  16'sd0,      1'b0},
        '{ROW_CODE_EXP, '0, 64'd14000,  16'sh8000,   1'b1},
        '{ROW_CODE_EXP, '0, 64'd17000,  16'sd80,     1'b1},
        '{ROW_CODE_EXP, '0, 64'd17001,  16'sd0,      1'b0},
        '{ROW_WRITE, txgtc_pkg::REG_WINDOW_LOW,  64'd20000,     16'sd0, 1'b0},
        '{ROW_WRITE, txgtc_pkg::REG_WINDOW_HIGH, 64'd10000,     16'sd0, 1'b0},
        '{ROW_CODE_EXP, '0, 64'd15000,  16'sd0,      1'b0}
    };

    logic                                  clk;
    logic                                  rst_n     = 1'b0;
    logic                                  in_valid  = 1'b0;
    logic                                  in_stall;
    logic [txgtc_pkg::P_CODE_W-1:0]        temp_code = '0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic signed [txgtc_pkg::P_GAIN_W-1:0] gain_offset;
    logic                                  accepted;
    logic                                  cfg_wr_en = 1'b0;
    logic [txgtc_pkg::P_CFG_IDX_W-1:0]     cfg_index = '0;
    logic [txgtc_pkg::P_CFG_DATA_W-1:0]    cfg_data  = '0;

    logic [63:0]                    gain_low_q  = '0;
    logic [63:0]                    gain_mid_q  = '0;
    logic [47:0]                    gain_high_q = '0;
    logic [txgtc_pkg::P_CODE_W-1:0] calib_q     = txgtc_pkg::P_CALIB_RESET;
    logic                           comp_en_q   = 1'b0;
    logic [txgtc_pkg::P_CODE_W-1:0] win_low_q   = txgtc_pkg::P_WIN_LOW_RESET;
    logic [txgtc_pkg::P_CODE_W-1:0] win_high_q  = txgtc_pkg::P_WIN_HI_RESET;

    int therm_base [txgtc_pkg::P_MAX_POINTS] = '{14420, 14675, 14910, 15124, 15350, 15575,
                                                 15790, 16022, 16234, 16466, 16694, 16922};

    t_gain_res gain_due_q [$];
    int        mismatch_cnt = 0;
    int        burst_left   = 8;

    int rx_cyc       = 0;
    int rx_hold      = 0;
    int rx_next_hold = 3000;
    int rx_mode      = 0;
    int rx_mode_left = 0;

    tx_gain_thermal_compensation_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_temp_code   (temp_code),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_gain_offset (gain_offset),
        .o_accepted    (accepted),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int gain_entry(input int idx);
        logic [63:0] w;
        if (idx < 4) begin
            w = gain_low_q;
        end else if (idx < 8) begin
            w = gain_mid_q;
        end else begin
            w = {16'h0000, gain_high_q};
        end
        return int'($signed(w[16 * (idx % 4) +: 16]));
    endfunction

    function automatic t_gain_res predict_gain(input logic [txgtc_pkg::P_CODE_W-1:0] code);
        t_gain_res r;
        int        pts [txgtc_pkg::P_MAX_POINTS];
        int        c;
        int        shift;
        int        k;
        int        lo;
        int        val;
        longint    num;
        longint    den;
        c      = int'(code);
        r.acc  = comp_en_q && (code >= win_low_q) && (code <= win_high_q);
        r.gain = '0;
        if (r.acc) begin
            shift = int'(calib_q) - therm_base[MID_IDX];
            for (k = 0; k < txgtc_pkg::P_TABLE_POINTS; k++) begin
                pts[k] = therm_base[k] + shift;
            end
            if (c <= pts[0]) begin
                val = gain_entry(0);
            end else if (c >= pts[LAST_IDX]) begin
                val = gain_entry(LAST_IDX);
            end else begin
                lo = 0;
                while (c >= pts[lo + 1]) lo++;
                num = longint'(c - pts[lo]) * longint'(gain_entry(lo + 1) - gain_entry(lo));
                den = longint'(pts[lo + 1] - pts[lo]);
                val = gain_entry(lo) + int'(num / den);
            end
            r.gain = val[txgtc_pkg::P_GAIN_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [txgtc_pkg::P_CODE_W-1:0] clamp_code(input int v);
        if (v < 0) return '0;
        if (v > CODE_MAX) return '1;
        return v[txgtc_pkg::P_CODE_W-1:0];
    endfunction

    function automatic logic [63:0] with_noise(input logic [txgtc_pkg::P_CODE_W-1:0] v);
        logic [63:0] w;
        w = {$urandom, $urandom};
        w[txgtc_pkg::P_CODE_W-1:0] = v;
        return w;
    endfunction

    function automatic logic [txgtc_pkg::P_CODE_W-1:0] pick_code();
        int t0;
        int tl;
        t0 = therm_base[0] + int'(calib_q) - therm_base[MID_IDX];
        tl = therm_base[LAST_IDX] + int'(calib_q) - therm_base[MID_IDX];
        case ($urandom_range(0, 9)) inside
            [0:5]: return clamp_code($urandom_range(0, tl - t0 + 40) + t0 - 20);
            [6:7]: begin
                if (win_low_q <= win_high_q) return $urandom_range(win_low_q, win_high_q);
                return $urandom_range(0, CODE_MAX);
            end
            8: begin
                case ($urandom_range(0, 3))
                    0:       return win_low_q - 1'b1;
                    1:       return win_low_q;
                    2:       return win_high_q;
                    default: return win_high_q + 1'b1;
                endcase
            end
            default: return $urandom_range(0, CODE_MAX);
        endcase
    endfunction

    task automatic write_reg(input logic [txgtc_pkg::P_CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            txgtc_pkg::REG_GAIN_LOW:    gain_low_q  = value;
            txgtc_pkg::REG_GAIN_MID:    gain_mid_q  = value;
            txgtc_pkg::REG_GAIN_HIGH:   gain_high_q = value[47:0];
            txgtc_pkg::REG_CALIB_CODE:  calib_q     = value[txgtc_pkg::P_CODE_W-1:0];
            txgtc_pkg::REG_COMP_ENABLE: comp_en_q   = value[0];
            txgtc_pkg::REG_WINDOW_LOW:  win_low_q   = value[txgtc_pkg::P_CODE_W-1:0];
            txgtc_pkg::REG_WINDOW_HIGH: win_high_q  = value[txgtc_pkg::P_CODE_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(input logic [txgtc_pkg::P_CODE_W-1:0] code, input t_gain_res due);
        in_valid  <= 1'b1;
        temp_code <= code;
        do @(posedge clk); while (in_stall);
        gain_due_q.push_back(due);
    endtask

    task automatic next_gap();
        burst_left--;
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (gain_due_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_phase(input int p);
        logic [63:0] lo_w;
        logic [63:0] mid_w;
        logic [63:0] hi_w;
        logic [63:0] en_w;
        int          cal;
        int          t0;
        int          tl;
        int          wl;
        int          wh;
        case ($urandom_range(0, 3))
            0: begin
                lo_w  = 64'h8000_7FFF_8000_7FFF;
                mid_w = 64'h7FFF_8000_7FFF_8000;
                hi_w  = {$urandom, $urandom} & ~64'hFFFF_0000_0000_0000 | 64'h8000_7FFF_8000;
            end
            1: begin
                lo_w  = '1;
                mid_w = '1;
                hi_w  = '1;
            end
            default: begin
                lo_w  = {$urandom, $urandom};
                mid_w = {$urandom, $urandom};
                hi_w  = {$urandom, $urandom};
            end
        endcase
        case (p)
            1:       cal = 10000;
            2:       cal = 20000;
            3:       cal = $urandom_range(0, CODE_MAX);
            default: cal = $urandom_range(10000, 20000);
        endcase
        t0 = therm_base[0] + cal - therm_base[MID_IDX];
        tl = therm_base[LAST_IDX] + cal - therm_base[MID_IDX];
        case (p)
            5: begin
                wl = $urandom_range(1, CODE_MAX);
                wh = $urandom_range(0, wl - 1);
            end
            6: begin
                wl = 0;
                wh = CODE_MAX;
            end
            7: begin
                wl = clamp_code($urandom_range(0, tl - t0) + t0);
                wh = wl;
            end
            default: begin
                wl = clamp_code(t0 - int'($urandom_range(0, 300)));
                wh = clamp_code(tl + int'($urandom_range(0, 300)));
            end
        endcase
        en_w    = {$urandom, $urandom};
        en_w[0] = (p != 4);
        write_reg(txgtc_pkg::REG_GAIN_LOW, lo_w);
        write_reg(txgtc_pkg::REG_GAIN_MID, mid_w);
        write_reg(txgtc_pkg::REG_GAIN_HIGH, hi_w);
        write_reg(txgtc_pkg::REG_CALIB_CODE, with_noise(cal[txgtc_pkg::P_CODE_W-1:0]));
        write_reg(txgtc_pkg::REG_COMP_ENABLE, en_w);
        write_reg(txgtc_pkg::REG_WINDOW_LOW, with_noise(wl[txgtc_pkg::P_CODE_W-1:0]));
        write_reg(txgtc_pkg::REG_WINDOW_HIGH, with_noise(wh[txgtc_pkg::P_CODE_W-1:0]));
    endtask

    // receiver: shifting stall patterns, with a long hold-off now and then
    always @(posedge clk) begin
        rx_cyc++;
        if (rx_hold > 0) begin
            rx_hold--;
            out_stall <= 1'b1;
        end else if (rx_cyc == rx_next_hold) begin
            rx_hold      = $urandom_range(150, 400);
            rx_next_hold = rx_cyc + $urandom_range(4000, 12000);
            out_stall   <= 1'b1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 300);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= rx_cyc[2];
            endcase
        end
    end

    always @(posedge clk) begin
        t_gain_res want;
        if (rst_n && out_valid && !out_stall) begin
            if (gain_due_q.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: unexpected word gain_offset %0d accepted %0b",
                         $time, gain_offset, accepted);
            end else begin
                want = gain_due_q.pop_front();
                if (gain_offset !== want.gain) begin
                    mismatch_cnt++;
                    $display("%0t: gain_offset expected %0d actual %0d",
                             $time, want.gain, gain_offset);
                end
                if (accepted !== want.acc) begin
                    mismatch_cnt++;
                    $display("%0t: accepted expected %0b actual %0b",
                             $time, want.acc, accepted);
                end
            end
        end
    end

    initial begin
        t_gain_res                      due;
        logic [txgtc_pkg::P_CODE_W-1:0] code;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR_ROWS; i++) begin
            code = DIR_ROWS[i].value[txgtc_pkg::P_CODE_W-1:0];
            case (DIR_ROWS[i].kind)
                ROW_WRITE: begin
                    drain();
                    write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].value);
                end
                ROW_CODE: begin
                    send_word(code, predict_gain(code));
                    next_gap();
                end
                default: begin
                    due.gain = DIR_ROWS[i].gain;
                    due.acc  = DIR_ROWS[i].acc;
                    send_word(code, due);
                    next_gap();
                end
            endcase
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            set_phase(p);
            repeat (PHASE_WORDS) begin
                code = pick_code();
                send_word(code, predict_gain(code));
                next_gap();
                if ($urandom_range(0, 199) == 0) begin
                    in_valid <= 1'b0;
                    do @(posedge clk); while (gain_due_q.size() != 0);
                end
            end
        end

        drain();
        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
